// ----- hw/rtl/keyed_hash_rate_limiter_top_defines.svh -----
// Assertion macros for the keyed hash rate limiter.
// Included by the top level; no other dependencies.
`ifndef KEYED_HASH_RATE_LIMITER_TOP_DEFINES_SVH
`define KEYED_HASH_RATE_LIMITER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only out of reset.
`define KHRL_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("khrl assertion failed");
// Checked on every edge, reset included.
`define KHRL_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("khrl assertion failed");
`else
`define KHRL_ASSERT_RST(label, clk, rst, prop)
`define KHRL_ASSERT_ALL(label, clk, prop)
`endif

`endif

// ----- hw/rtl/khrl_pkg.sv -----
// Shared types, codes and the mixing round of the keyed hash rate limiter.
// No dependencies; used by khrl_hash and keyed_hash_rate_limiter_top.
`default_nettype none

package khrl_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C2 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND   = 2'd2;

  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_REKEY = 1'b1;

  localparam logic [1:0] KIND_IPV4 = 2'd0;
  localparam logic [1:0] KIND_IPV6 = 2'd1;

  localparam logic [1:0] VERDICT_OK          = 2'd0;
  localparam logic [1:0] VERDICT_LIMITED     = 2'd1;
  localparam logic [1:0] VERDICT_UNSUPPORTED = 2'd2;

  localparam logic [31:0] SWEEP_PERIOD_RST = 32'd4096;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sip_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] k0;
    logic [63:0] k1;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] h0;
    logic [63:0] h1;
  } hash_rsp_t;

  function automatic logic [63:0] rol64(logic [63:0] x, int unsigned n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic sip_state_t sip_round(sip_state_t s);
    sip_state_t r;
    r = s;
    r.a = r.a + r.b; r.b = rol64(r.b, 13); r.b = r.b ^ r.a; r.a = rol64(r.a, 32);
    r.c = r.c + r.d; r.d = rol64(r.d, 16); r.d = r.d ^ r.c;
    r.a = r.a + r.d; r.d = rol64(r.d, 21); r.d = r.d ^ r.a;
    r.c = r.c + r.b; r.b = rol64(r.b, 17); r.b = r.b ^ r.c; r.c = rol64(r.c, 32);
    return r;
  endfunction

  function automatic logic [63:0] sip_fold(sip_state_t s);
    return s.a ^ s.b ^ s.c ^ s.d;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/khrl_hash.sv -----
// Iterative keyed hash: one mixing round per cycle, six rounds per request.
// Depends on khrl_pkg (state type, round function, request/response structs).
`default_nettype none

module khrl_hash
  import khrl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire hash_req_t req,
  output hash_rsp_t      rsp
);

  localparam logic [2:0] RND_MSG0  = 3'd0;
  localparam logic [2:0] RND_MSG1  = 3'd1;
  localparam logic [2:0] RND_FIRST = 3'd4;
  localparam logic [2:0] RND_LAST  = 3'd5;

  sip_state_t  st;
  sip_state_t  st_rnd;
  sip_state_t  st_next;
  sip_state_t  st_init;
  logic [63:0] w0;
  logic [63:0] w1;
  logic [63:0] h0;
  logic [2:0]  rnd;
  logic        busy;
  logic        done;

  always_comb begin
    st_init.a = req.k0;
    st_init.b = req.k1;
    st_init.c = SIP_C0 ^ SIP_C1 ^ req.k0;
    st_init.d = SIP_C2 ^ SIP_C3 ^ req.k1 ^ req.w0;
  end

  // message words are folded in after each of the first two rounds
  always_comb begin
    st_rnd  = sip_round(st);
    st_next = st_rnd;
    case (rnd)
      RND_MSG0: begin
        st_next.a = st_rnd.a ^ w0;
        st_next.d = st_rnd.d ^ w1;
      end
      RND_MSG1: begin
        st_next.a = st_rnd.a ^ w1;
        st_next.c = st_rnd.c ^ SIP_FINAL_XOR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= RND_MSG0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rnd  <= RND_MSG0;
      end else if (busy) begin
        rnd <= rnd + 3'd1;
        if (rnd == RND_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      st <= st_init;
      w0 <= req.w0;
      w1 <= req.w1;
    end else if (busy) begin
      st <= st_next;
      if (rnd == RND_FIRST) begin
        h0 <= sip_fold(st_rnd);
      end
    end
  end

  assign rsp.done = done;
  assign rsp.h0   = h0;
  assign rsp.h1   = sip_fold(st);

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_hash_rate_limiter_top.sv -----
// Keyed hash rate limiter: counter memory, decay sweep, key state and sequencer.
// Depends on khrl_pkg, khrl_hash and keyed_hash_rate_limiter_top_defines.svh.
//
//   channel   dir   handshake            payload
//   in        in    in_valid/in_ready    command addr_kind ipv6_* ipv4_addr peak_limit
//   out       out   out_valid/out_ready  verdict
//   cfg       in    cfg_valid/cfg_ready  cfg_index cfg_data
//
// A hit runs six hash rounds in the shared round unit, then two read-modify-writes
// on the single counter memory, between one accept and the next. A rekey runs the
// hash rounds only, an unsupported address none. After reset a clearing pass
// writes NUM_SLOTS counters, one per cycle, with in_ready low; cfg is always ready.
// A result waiting on out_ready holds the sequencer before its next result only.
`default_nettype none
`include "keyed_hash_rate_limiter_top_defines.svh"

module keyed_hash_rate_limiter_top
  import khrl_pkg::*;
#(
  parameter int NUM_SLOTS    = 4096,
  parameter int COUNTER_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 command,
  input  wire logic [1:0]           addr_kind,
  input  wire logic [63:0]          ipv6_first_word,
  input  wire logic [63:0]          ipv6_second_word,
  input  wire logic [31:0]          ipv4_addr,
  input  wire logic [31:0]          peak_limit,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                verdict,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;
  localparam logic [IDX_W-1:0] IDX_MASK  = IDX_W'(NUM_SLOTS - 1);
  localparam logic [31:0]      SLOTS_32  = 32'(NUM_SLOTS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_BUMP_I = 3'd3;
  localparam logic [2:0] S_BUMP_J = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [IDX_W-1:0]        clr_addr;
  logic [31:0]             sweep_period;
  logic [31:0]             sweep_pos;
  logic [31:0]             sweep_pos_next;
  logic [31:0]             period_eff;
  logic [63:0]             cur_key_first;
  logic [63:0]             cur_key_second;
  logic                    is_rekey;
  logic                    decay_wr;
  logic [IDX_W-1:0]        decay_addr;
  logic [31:0]             peak;
  logic [IDX_W-1:0]        idx_i;
  logic [IDX_W-1:0]        idx_j;
  logic [COUNTER_BITS-1:0] val_i;
  logic                    below_i;
  logic [1:0]              pending;
  logic [1:0]              pending_next;

  logic                    in_beat;
  logic                    kind_ok;
  logic                    sweep_in_table;
  logic                    out_free;

  logic [COUNTER_BITS-1:0] mem [NUM_SLOTS];
  logic [COUNTER_BITS-1:0] rd_data;
  logic [IDX_W-1:0]        raddr;
  logic                    mem_we;
  logic [IDX_W-1:0]        waddr;
  logic [COUNTER_BITS-1:0] wdata;

  logic [COUNTER_BITS-1:0] bump_old;
  logic [COUNTER_BITS-1:0] bump_new;
  logic                    bump_below;
  logic [IDX_W-1:0]        hidx_i;
  logic [IDX_W-1:0]        hidx_j;

  hash_req_t hash_req;
  hash_rsp_t hash_rsp;

  khrl_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hash_req),
    .rsp (hash_rsp)
  );

  assign in_ready       = (state == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign in_beat        = in_valid && in_ready;
  assign kind_ok        = (addr_kind == KIND_IPV4) || (addr_kind == KIND_IPV6);
  assign sweep_in_table = (sweep_pos < SLOTS_32);
  assign out_free       = !out_valid || out_ready;
  assign period_eff     = (sweep_period < SLOTS_32) ? SLOTS_32 : sweep_period;
  assign hidx_i         = hash_rsp.h0[IDX_W-1:0] & IDX_MASK;
  assign hidx_j         = hash_rsp.h1[IDX_W-1:0] & IDX_MASK;

  always_comb begin
    sweep_pos_next = sweep_pos + 32'd1;
    if (sweep_pos_next >= period_eff) begin
      sweep_pos_next = '0;
    end
  end

  // hash request: zero message on rekey, IPv4 lands in the upper half of word 1
  always_comb begin
    hash_req.start = in_beat && ((command == CMD_REKEY) || kind_ok);
    hash_req.k0    = cur_key_first;
    hash_req.k1    = cur_key_second;
    hash_req.w0    = '0;
    hash_req.w1    = '0;
    if (command == CMD_HIT) begin
      if (addr_kind == KIND_IPV6) begin
        hash_req.w0 = ipv6_first_word;
        hash_req.w1 = ipv6_second_word;
      end else begin
        hash_req.w1 = {ipv4_addr, 32'd0};
      end
    end
  end

  // slot j reads the value just written to slot i when they coincide
  always_comb begin
    bump_old   = ((state == S_BUMP_J) && (idx_j == idx_i)) ? val_i : rd_data;
    bump_below = CMP_W'(bump_old) < CMP_W'(peak);
    bump_new   = (bump_below && !(&bump_old)) ? bump_old + COUNTER_BITS'(1) : bump_old;
  end

  always_comb begin
    raddr = sweep_pos[IDX_W-1:0];
    case (state)
      S_HASH:   raddr = hidx_i;
      S_BUMP_I: raddr = idx_j;
      default:  raddr = sweep_pos[IDX_W-1:0];
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = clr_addr;
    wdata  = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_HASH: begin
        mem_we = decay_wr;
        waddr  = decay_addr;
        wdata  = rd_data >> 1;
      end
      S_BUMP_I: begin
        mem_we = 1'b1;
        waddr  = idx_i;
        wdata  = bump_new;
      end
      S_BUMP_J: begin
        mem_we = 1'b1;
        waddr  = idx_j;
        wdata  = bump_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_comb begin
    state_next   = state;
    pending_next = pending;
    case (state)
      S_CLEAR: begin
        if (clr_addr == IDX_MASK) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          if (command == CMD_REKEY || kind_ok) begin
            state_next = S_HASH;
          end else begin
            pending_next = VERDICT_UNSUPPORTED;
            state_next   = S_FINISH;
          end
        end
      end
      S_HASH: begin
        if (hash_rsp.done) begin
          if (is_rekey) begin
            pending_next = VERDICT_OK;
            state_next   = S_FINISH;
          end else begin
            state_next = S_BUMP_I;
          end
        end
      end
      S_BUMP_I: begin
        state_next = S_BUMP_J;
      end
      S_BUMP_J: begin
        pending_next = (below_i || bump_below) ? VERDICT_OK : VERDICT_LIMITED;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
      decay_wr       <= 1'b0;
      sweep_pos      <= '0;
      sweep_period   <= SWEEP_PERIOD_RST;
      cur_key_first  <= '0;
      cur_key_second <= '0;
    end else begin
      state    <= state_next;
      decay_wr <= 1'b0;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (in_beat && command == CMD_HIT && kind_ok) begin
        decay_wr  <= sweep_in_table;
        sweep_pos <= sweep_pos_next;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SWEEP_PERIOD: sweep_period   <= cfg_data[31:0];
          REG_KEY_FIRST:    cur_key_first  <= cfg_data;
          REG_KEY_SECOND:   cur_key_second <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_HASH && hash_rsp.done && is_rekey) begin
        cur_key_first  <= hash_rsp.h0;
        cur_key_second <= hash_rsp.h1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pending <= pending_next;
    if (in_beat) begin
      is_rekey   <= (command == CMD_REKEY);
      peak       <= peak_limit;
      decay_addr <= sweep_pos[IDX_W-1:0];
    end
    if (state == S_HASH && hash_rsp.done) begin
      idx_i <= hidx_i;
      idx_j <= hidx_j;
    end
    if (state == S_BUMP_I) begin
      val_i   <= bump_new;
      below_i <= bump_below;
    end
    if (state == S_FINISH && out_free) begin
      verdict <= pending;
    end
  end

  `KHRL_ASSERT_RST(a_done_in_hash, clk, rst, hash_rsp.done |-> (state == S_HASH))
  `KHRL_ASSERT_RST(a_no_write_idle, clk, rst, (state == S_IDLE) |-> !mem_we)
  `KHRL_ASSERT_RST(a_unsup_verdict, clk, rst,
    (in_beat && command == CMD_HIT && !kind_ok) |=>
      (state == S_FINISH && pending == VERDICT_UNSUPPORTED))
  `KHRL_ASSERT_RST(a_hit_sweeps, clk, rst,
    (in_beat && command == CMD_HIT && kind_ok) |=> (state == S_HASH && !$stable(sweep_pos)
      || $past(sweep_pos_next) == $past(sweep_pos)))

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for keyed_hash_rate_limiter_top.
// Needs khrl_pkg and the limiter RTL; predicts each verdict from a local copy
// of the counter table, decay sweep and hash key state.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import khrl_pkg::*;

  localparam int N_SLOTS = 4096;
  localparam logic [1:0] KIND_BAD  = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam logic [63:0] IV0 = 64'h736f6d6570736575;
  localparam logic [63:0] IV1 = 64'h6c7967656e657261;
  localparam logic [63:0] IV2 = 64'h646f72616e646f6d;
  localparam logic [63:0] IV3 = 64'h7465646279746573;
  localparam logic [63:0] TAIL_XOR = 64'h00000000000000ff;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  kind;
    logic [63:0] v6a;
    logic [63:0] v6b;
    logic [31:0] v4;
    logic [31:0] peak;
  } hit_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } mix_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = 1'b0;
  logic [1:0]           addr_kind = 2'd0;
  logic [63:0]          ipv6_first_word = 64'd0;
  logic [63:0]          ipv6_second_word = 64'd0;
  logic [31:0]          ipv4_addr = 32'd0;
  logic [31:0]          peak_limit = 32'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           verdict;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SWEEP_PERIOD;
  logic [63:0]          cfg_data = 64'd0;

  keyed_hash_rate_limiter_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .addr_kind(addr_kind),
    .ipv6_first_word(ipv6_first_word), .ipv6_second_word(ipv6_second_word),
    .ipv4_addr(ipv4_addr), .peak_limit(peak_limit),
    .out_valid(out_valid), .out_ready(out_ready), .verdict(verdict),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted block state
  logic [31:0] slots [N_SLOTS] = '{default: 32'd0};
  logic [31:0] sweep_pos = 32'd0;
  logic [31:0] sweep_period = 32'd4096;
  logic [63:0] cur_k0 = 64'd0;
  logic [63:0] cur_k1 = 64'd0;

  hit_t        pending [$];
  logic [1:0]  verdicts_due [$];
  hit_t        on_bus;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          errors = 0;
  int          n_beats = 0;
  int          n_limited = 0;
  int          n_rekey = 0;
  int          n_unsup = 0;
  int          n_cfg = 0;
  logic [1:0]  want;
  logic [31:0] pool_v4 [16];
  logic [63:0] pool_a [16];
  logic [63:0] pool_b [16];

  function automatic logic [63:0] rotl(logic [63:0] x, int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic mix_t mix_round(mix_t s);
    s.a = s.a + s.b; s.b = rotl(s.b, 13); s.b = s.b ^ s.a; s.a = rotl(s.a, 32);
    s.c = s.c + s.d; s.d = rotl(s.d, 16); s.d = s.d ^ s.c;
    s.a = s.a + s.d; s.d = rotl(s.d, 21); s.d = s.d ^ s.a;
    s.c = s.c + s.b; s.b = rotl(s.b, 17); s.b = s.b ^ s.c; s.c = rotl(s.c, 32);
    return s;
  endfunction

  // returns {second word, first word}
  function automatic logic [127:0] keyed_digest(logic [63:0] w0, logic [63:0] w1,
                                                logic [63:0] k0, logic [63:0] k1);
    mix_t        s;
    logic [63:0] h0;
    s.a = k0;
    s.b = k1;
    s.c = IV0 ^ IV1 ^ k0;
    s.d = IV2 ^ IV3 ^ k1;
    s.d = s.d ^ w0; s = mix_round(s); s.a = s.a ^ w0;
    s.d = s.d ^ w1; s = mix_round(s); s.a = s.a ^ w1;
    s.c = s.c ^ TAIL_XOR;
    s = mix_round(s);
    s = mix_round(s);
    s = mix_round(s);
    h0 = s.a ^ s.b ^ s.c ^ s.d;
    s = mix_round(s);
    return {s.a ^ s.b ^ s.c ^ s.d, h0};
  endfunction

  // true when the slot was below the peak; saturates at all ones
  function automatic bit bump_slot(logic [11:0] idx, logic [31:0] peak);
    if (slots[idx] < peak) begin
      if (slots[idx] != 32'hffffffff) slots[idx] = slots[idx] + 32'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] predict_verdict(hit_t h);
    logic [63:0]  w0;
    logic [63:0]  w1;
    logic [127:0] dg;
    logic [31:0]  wrap_at;
    bit           below_i;
    bit           below_j;
    if (h.cmd == CMD_REKEY) begin
      dg = keyed_digest(64'd0, 64'd0, cur_k0, cur_k1);
      cur_k0 = dg[63:0];
      cur_k1 = dg[127:64];
      return VERDICT_OK;
    end
    if (h.kind == KIND_IPV4) begin
      w0 = 64'd0;
      w1 = {h.v4, 32'd0};
    end else if (h.kind == KIND_IPV6) begin
      w0 = h.v6a;
      w1 = h.v6b;
    end else begin
      return VERDICT_UNSUPPORTED;
    end
    if (sweep_pos < N_SLOTS) slots[sweep_pos[11:0]] = slots[sweep_pos[11:0]] >> 1;
    wrap_at = (sweep_period < N_SLOTS) ? N_SLOTS : sweep_period;
    sweep_pos = sweep_pos + 32'd1;
    if (sweep_pos >= wrap_at) sweep_pos = 32'd0;
    dg = keyed_digest(w0, w1, cur_k0, cur_k1);
    below_i = bump_slot(dg[11:0], h.peak);
    below_j = bump_slot(dg[75:64], h.peak);
    return (below_i || below_j) ? VERDICT_OK : VERDICT_LIMITED;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic hit_t mk(logic cmd, logic [1:0] kind, logic [63:0] a,
                              logic [63:0] b, logic [31:0] v4, logic [31:0] peak);
    hit_t h;
    h.cmd = cmd; h.kind = kind; h.v6a = a; h.v6b = b; h.v4 = v4; h.peak = peak;
    return h;
  endfunction

  // mostly hits on a small address pool with low peaks so limits trip often
  function automatic hit_t rand_hit();
    hit_t h;
    int   r;
    int   p;
    h = mk(CMD_HIT, 2'($urandom_range(1)), rand64(), rand64(), $urandom, 32'd0);
    r = $urandom_range(99);
    if (r < 3) h.cmd = CMD_REKEY;
    else if (r < 8) h.kind = $urandom_range(1) ? KIND_BAD : KIND_RSVD;
    if ($urandom_range(99) < 75) begin
      p = $urandom_range(15);
      h.v4 = pool_v4[p];
      h.v6a = pool_a[p];
      h.v6b = pool_b[p];
    end
    r = $urandom_range(99);
    if (r < 70) h.peak = $urandom_range(6, 1);
    else if (r < 80) h.peak = 32'd0;
    else if (r < 90) h.peak = $urandom;
    else h.peak = 32'hffffffff;
    return h;
  endfunction

  task automatic flag_error(string what, logic [1:0] exp_v, logic [1:0] got_v);
    errors++;
    if (errors <= 10)
      $display("%0t: %s verdict: expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      REG_SWEEP_PERIOD: sweep_period = data[31:0];
      REG_KEY_FIRST:    cur_k0 = data;
      REG_KEY_SECOND:   cur_k1 = data;
      default: ;
    endcase
  endtask

  // wait for every beat to drain, then give the sequencer time to go idle
  task automatic settle();
    while (pending.size() != 0 || in_valid || verdicts_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic run_phase(int s_idle, int r_stall, logic [31:0] period,
                           logic [63:0] k0, logic [63:0] k1, int n);
    settle();
    write_reg(REG_SWEEP_PERIOD, {32'd0, period});
    write_reg(REG_KEY_FIRST, k0);
    write_reg(REG_KEY_SECOND, k1);
    @(negedge clk);
    send_idle = s_idle;
    recv_stall = r_stall;
    for (int i = 0; i < 16; i++) begin
      pool_v4[i] = $urandom;
      pool_a[i] = rand64();
      pool_b[i] = rand64();
    end
    repeat (n) pending.push_back(rand_hit());
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // input driver: predicts each beat as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (on_bus.cmd == CMD_REKEY) n_rekey++;
        verdicts_due.push_back(predict_verdict(on_bus));
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
          on_bus = pending.pop_front();
          command          <= on_bus.cmd;
          addr_kind        <= on_bus.kind;
          ipv6_first_word  <= on_bus.v6a;
          ipv6_second_word <= on_bus.v6b;
          ipv4_addr        <= on_bus.v4;
          peak_limit       <= on_bus.peak;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          flag_error("unexpected", 2'd0, verdict);
        end else begin
          want = verdicts_due.pop_front();
          n_beats++;
          if (want == VERDICT_LIMITED) n_limited++;
          if (want == VERDICT_UNSUPPORTED) n_unsup++;
          if (verdict !== want) flag_error("wrong", want, verdict);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: below-table period, extreme keys, corner fields
    run_phase(0, 0, 32'd0, 64'd0, 64'hffffffffffffffff, 0);
    pending.push_back(mk(CMD_HIT, KIND_IPV4, 64'd0, 64'd0, 32'd0, 32'd1));
    pending.push_back(mk(CMD_HIT, KIND_IPV4, '1, '1, 32'hffffffff, 32'hffffffff));
    pending.push_back(mk(CMD_HIT, KIND_IPV6, 64'd0, 64'd0, 32'd0, 32'd5));
    pending.push_back(mk(CMD_HIT, KIND_IPV6, '1, '1, 32'hffffffff, 32'd0));
    pending.push_back(mk(CMD_HIT, KIND_BAD, 64'd0, 64'd0, 32'd0, 32'd0));
    pending.push_back(mk(CMD_HIT, KIND_RSVD, '1, '1, 32'hffffffff, 32'hffffffff));
    pending.push_back(mk(CMD_REKEY, KIND_IPV4, '1, '1, 32'hffffffff, 32'hffffffff));
    // same client until both slots reach the peak
    repeat (5) pending.push_back(mk(CMD_HIT, KIND_IPV4, 64'd0, 64'd0, 32'hc0a80001, 32'd2));
    pending.push_back(mk(CMD_REKEY, KIND_RSVD, 64'd0, 64'd0, 32'd0, 32'd0));
    repeat (3) pending.push_back(mk(CMD_HIT, KIND_IPV4, 64'd0, 64'd0, 32'hc0a80001, 32'd2));
    repeat (2) pending.push_back(mk(CMD_HIT, KIND_IPV6, 64'h5555aaaa5555aaaa,
                                    64'haaaa5555aaaa5555, 32'h12345678, 32'd1));
    pending.push_back(mk(CMD_HIT, KIND_BAD, '1, 64'd0, 32'h80000001, 32'd0));

    run_phase(0, 0, 32'hffffffff, rand64(), rand64(), 445);
    run_phase(51, 0, 32'd4097, 64'd0, 64'hffffffffffffffff, 445);
    run_phase(0, 51, $urandom_range(32'hffffffff, 32'd4096), rand64(), rand64(), 445);
    run_phase(28, 28, 32'd4096, 64'hffffffffffffffff, 64'hffffffffffffffff, 445);

    // short runs after raising and then restoring the period
    run_phase(0, 0, 32'd8192, rand64(), rand64(), 25);
    run_phase(28, 28, 32'd4096, rand64(), 64'd0, 25);

    settle();
    repeat (30) @(negedge clk);
    $display("covered %0d beats over %0d register writes: %0d limited, %0d rekeys, %0d unsupported",
             n_beats, n_cfg, n_limited, n_rekey, n_unsup);
    $display("four idle mixes with varied keys and sweep periods; %0d failures", errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
